FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/dks_pkg.sv
// Package: DES key schedule types, permutation tables and helper functions
`timescale 1ns / 1ps

package dks_pkg;

  localparam int KeyW   = 64;
  localparam int HalfW  = 28;
  localparam int SubW   = 48;
  localparam int RoundW = 4;
  localparam logic [RoundW-1:0] LastRound = 4'd15;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              step;
    logic [RoundW-1:0] round;
  } dp_cmd_t;

  typedef logic [7:0] tab_entry_t;

  localparam tab_entry_t PC1_C [HalfW] = '{
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,  8'd58, 8'd50,
    8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35,
    8'd27, 8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36};

  localparam tab_entry_t PC1_D [HalfW] = '{
    8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7,  8'd62, 8'd54,
    8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37,
    8'd29, 8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4};

  localparam tab_entry_t PC2 [SubW] = '{
    8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,  8'd3,  8'd28, 8'd15, 8'd6,
    8'd21, 8'd10, 8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,  8'd16, 8'd7,
    8'd27, 8'd20, 8'd13, 8'd2,  8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55,
    8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48, 8'd44, 8'd49, 8'd39, 8'd56,
    8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32};

  function automatic logic [HalfW-1:0] pc1_c(input logic [KeyW-1:0] key);
    logic [HalfW-1:0] v;
    v = '0;
    for (int i = 0; i < HalfW; i++) begin
      v[HalfW-1-i] = key[KeyW - int'(PC1_C[i])];
    end
    return v;
  endfunction

  function automatic logic [HalfW-1:0] pc1_d(input logic [KeyW-1:0] key);
    logic [HalfW-1:0] v;
    v = '0;
    for (int i = 0; i < HalfW; i++) begin
      v[HalfW-1-i] = key[KeyW - int'(PC1_D[i])];
    end
    return v;
  endfunction

  function automatic logic [SubW-1:0] pc2(input logic [2*HalfW-1:0] cd);
    logic [SubW-1:0] k;
    k = '0;
    for (int i = 0; i < SubW; i++) begin
      k[SubW-1-i] = cd[2*HalfW - int'(PC2[i])];
    end
    return k;
  endfunction

  // Single-place rotate in rounds 0, 1, 8 and 15; two places otherwise
  function automatic logic single_rot(input logic [RoundW-1:0] round);
    return (round == 4'd0) || (round == 4'd1) || (round == 4'd8) || (round == 4'd15);
  endfunction

  function automatic logic [HalfW-1:0] rotl(input logic [HalfW-1:0] x, input logic one);
    return one ? {x[HalfW-2:0], x[HalfW-1]} : {x[HalfW-3:0], x[HalfW-1:HalfW-2]};
  endfunction

endpackage

FILE: rtl/dks_ctrl.sv
// Controller: round sequencing, handshakes and output valid flag
`timescale 1ns / 1ps

module dks_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output dks_pkg::dp_cmd_t cmd
);

  dks_pkg::state_t                 state_r, state_nxt;
  logic [dks_pkg::RoundW-1:0]      round_r, round_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            step;
  logic                            accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dks_pkg::ST_IDLE;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    step      = 1'b0;
    in_tready = 1'b0;
    unique case (state_r)
      dks_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      dks_pkg::ST_RUN: begin
        step = !out_valid_r || out_tready;
        // Next key may enter on the final round
        in_tready = step && (round_r == dks_pkg::LastRound);
        if (step) begin
          round_nxt = round_r + 4'd1;
          if (round_r == dks_pkg::LastRound) begin
            state_nxt = dks_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = dks_pkg::ST_IDLE;
      end
    endcase
    accept = in_tvalid && in_tready;
    if (accept) begin
      state_nxt = dks_pkg::ST_RUN;
      round_nxt = '0;
    end
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign cmd.load   = accept;
  assign cmd.step   = step;
  assign cmd.round  = round_r;

endmodule

FILE: rtl/dks_datapath.sv
// Datapath: C/D half registers, rotators, PC-1/PC-2 and output register
`timescale 1ns / 1ps

module dks_datapath (
  input  logic                         clk,
  input  logic [dks_pkg::KeyW-1:0]     key,
  input  dks_pkg::dp_cmd_t             cmd,
  output logic [dks_pkg::SubW-1:0]     sub_key,
  output logic [dks_pkg::RoundW-1:0]   sub_round,
  output logic                         sub_last
);

  logic [dks_pkg::HalfW-1:0]  c_r, c_nxt;
  logic [dks_pkg::HalfW-1:0]  d_r, d_nxt;
  logic [dks_pkg::HalfW-1:0]  c_rot, d_rot;
  logic [dks_pkg::SubW-1:0]   key_r;
  logic [dks_pkg::RoundW-1:0] round_r;
  logic                       last_r;
  logic                       one;

  always_comb begin
    one   = dks_pkg::single_rot(cmd.round);
    c_rot = dks_pkg::rotl(c_r, one);
    d_rot = dks_pkg::rotl(d_r, one);
    c_nxt = c_r;
    d_nxt = d_r;
    if (cmd.load) begin
      c_nxt = dks_pkg::pc1_c(key);
      d_nxt = dks_pkg::pc1_d(key);
    end else if (cmd.step) begin
      c_nxt = c_rot;
      d_nxt = d_rot;
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
    d_r <= d_nxt;
    if (cmd.step) begin
      key_r   <= dks_pkg::pc2({c_rot, d_rot});
      round_r <= cmd.round;
      last_r  <= (cmd.round == dks_pkg::LastRound);
    end
  end

  assign sub_key   = key_r;
  assign sub_round = round_r;
  assign sub_last  = last_r;

endmodule

FILE: rtl/des_round_key_generator_core.sv
// Top level: DES key schedule, one key in, sixteen round keys out
//
// Input channel in_*: one 64-bit DES key per item (bit 1 of the standard
// numbering at bit 63, parity bits ignored).
// Output channel out_*: sixteen items per key, round keys 0 to 15 in order.
// out_tdata carries the 48-bit round key, out_tuser the round number and
// out_tlast marks round 15.
// The key is loaded into the C/D half registers; each round then passes
// the shared rotate/PC-2 unit and is registered in the output register.
// The next key is taken in the cycle of round 15, so with a free-running
// receiver the round keys of successive keys follow without a gap.
// A stalled receiver freezes the round sequence; the finished round key
// waits in the output register. The last round key of a run may wait
// there while the next key is taken.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_tvalid; a run in progress is abandoned.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module des_round_key_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] cipher_key
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [47:0] round_key
  output logic [3:0]  out_tuser,  // [3:0] round_index
  output logic        out_tlast   // last_round
);

  dks_pkg::dp_cmd_t cmd;

  dks_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  dks_datapath u_dp (
    .clk       (clk),
    .key       (in_tdata),
    .cmd       (cmd),
    .sub_key   (out_tdata),
    .sub_round (out_tuser),
    .sub_last  (out_tlast)
  );

  `ASSERT_IMPL(a_last_is_round15, clk, rst_n, out_tvalid && out_tlast, out_tuser == 4'd15)
  `ASSERT_NEXT(a_rounds_advance, clk, rst_n, out_tvalid && out_tready && !out_tlast,
               out_tvalid && (out_tuser == $past(out_tuser) + 4'd1))
  `ASSERT_IMPL(a_ready_only_last_held, clk, rst_n, in_tready && out_tvalid && !out_tready,
               out_tlast)

endmodule
